// ===== rtl/core/linear_sweep_oscillator_top_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LINEAR_SWEEP_OSCILLATOR_TOP_MACROS_SVH
`define LINEAR_SWEEP_OSCILLATOR_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LSO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define LSO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LSO_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lso_pkg.sv =====
package lso_pkg;

    // Configuration register widths
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int START_INCR_W = 31;
    localparam int INCR_W       = 32;
    localparam int COUNT_W      = 20;
    localparam int AMP_W        = 15;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_INCR   = 2'd0,
        CFG_INCR_STEP    = 2'd1,
        CFG_SAMPLE_COUNT = 2'd2,
        CFG_AMPLITUDE    = 2'd3
    } t_cfg_reg;

    // Configuration register file contents
    typedef struct packed {
        logic [START_INCR_W-1:0] start_incr;
        logic signed [INCR_W-1:0] incr_step;
        logic [COUNT_W-1:0]      sample_count;
        logic [AMP_W-1:0]        amplitude;
    } t_cfg;

    // Per-stage control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic active;
    } t_stage_ctl;

endpackage

// ===== rtl/core/lso_cfg_regs.sv =====
module lso_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lso_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lso_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output lso_pkg::t_cfg                      o_cfg
);

    lso_pkg::t_cfg r_cfg;

    // Register writes, decoded by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (lso_pkg::t_cfg_reg'(i_cfg_index))
                lso_pkg::CFG_START_INCR: begin
                    r_cfg.start_incr <= i_cfg_data[lso_pkg::START_INCR_W-1:0];
                end
                lso_pkg::CFG_INCR_STEP: begin
                    r_cfg.incr_step <= $signed(i_cfg_data[lso_pkg::INCR_W-1:0]);
                end
                lso_pkg::CFG_SAMPLE_COUNT: begin
                    r_cfg.sample_count <= i_cfg_data[lso_pkg::COUNT_W-1:0];
                end
                lso_pkg::CFG_AMPLITUDE: begin
                    r_cfg.amplitude <= i_cfg_data[lso_pkg::AMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/lso_phase.sv =====
module lso_phase #(
    parameter int PHASE_BITS,
    parameter int ADDR_BITS,
    parameter int SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_load,
    input  logic                          i_restart,
    input  logic signed [SAMPLE_BITS-1:0] i_mix_in,
    input  lso_pkg::t_cfg                 i_cfg,
    output lso_pkg::t_stage_ctl           o_ctl,
    output logic [ADDR_BITS-1:0]          o_addr,
    output logic signed [SAMPLE_BITS-1:0] o_mix
);

    // Chirp state
    logic [PHASE_BITS-1:0]               r_phase;
    logic [lso_pkg::INCR_W-1:0]          r_incr;
    logic [lso_pkg::COUNT_W-1:0]         r_index;

    // Stage register
    lso_pkg::t_stage_ctl                 r_ctl;
    logic [ADDR_BITS-1:0]                r_addr;
    logic signed [SAMPLE_BITS-1:0]       r_mix;

    logic                                w_accept;
    logic [PHASE_BITS-1:0]               w_phase_base;
    logic [lso_pkg::INCR_W-1:0]          w_incr_base;
    logic [lso_pkg::COUNT_W-1:0]         w_index_base;
    logic                                w_active;
    logic [PHASE_BITS-1:0]               w_phase_adv;
    logic [PHASE_BITS-1:0]               n_phase;
    logic [lso_pkg::INCR_W-1:0]          n_incr;
    logic [lso_pkg::COUNT_W-1:0]         n_index;

    assign w_accept = i_in_valid && i_load;

    // Restart applies before the word is used
    always_comb begin
        w_phase_base = i_restart ? '0 : r_phase;
        w_incr_base  = i_restart ? {1'b0, i_cfg.start_incr} : r_incr;
        w_index_base = i_restart ? '0 : r_index;
        w_active     = w_index_base < i_cfg.sample_count;
        w_phase_adv  = w_phase_base + PHASE_BITS'(w_incr_base);
        n_phase      = w_active ? w_phase_adv : w_phase_base;
        n_incr       = w_active ? w_incr_base + $unsigned(i_cfg.incr_step) : w_incr_base;
        n_index      = w_active ? w_index_base + lso_pkg::COUNT_W'(1) : w_index_base;
    end

    // State update and stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_incr  <= '0;
            r_index <= '0;
            r_ctl   <= '0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_incr  <= n_incr;
                r_index <= n_index;
            end
            if (i_load) begin
                r_ctl.valid  <= i_in_valid;
                r_ctl.active <= w_active;
            end
        end
    end

    // Table address is the top of the advanced phase
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr <= w_phase_adv[PHASE_BITS-1 -: ADDR_BITS];
            r_mix  <= i_mix_in;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_addr = r_addr;
    assign o_mix  = r_mix;

endmodule

// ===== rtl/core/lso_sine_rom.sv =====
module lso_sine_rom #(
    parameter int SINE_TABLE_DEPTH,
    parameter int SAMPLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  lso_pkg::t_stage_ctl                   i_ctl,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   i_addr,
    input  logic signed [SAMPLE_BITS-1:0]         i_mix,
    output lso_pkg::t_stage_ctl                   o_ctl,
    output logic signed [SAMPLE_BITS-1:0]         o_sine,
    output logic signed [SAMPLE_BITS-1:0]         o_mix
);

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

    // Q30 angles
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF    = 64'd536870912;
    localparam logic [63:0] FULL_SCALE  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    // Taylor divisors (2n)(2n+1)
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    typedef logic signed [SAMPLE_BITS-1:0] t_rom [SINE_TABLE_DEPTH];

    // sin(x) on [0, pi/2], Q30 in and out
    function automatic logic [63:0] f_sine_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return (sum > Q30_ONE) ? Q30_ONE : sum;
    endfunction

    // Full-wave table with quadrant folding, magnitude rounded half up
    function automatic t_rom f_build();
        t_rom        rom;
        logic [63:0] a;
        logic [63:0] mag;
        logic        neg;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            a   = (64'(k) * Q30_TWO_PI) >> ADDR_BITS;
            neg = 1'b0;
            if (a >= Q30_PI) begin
                a   = a - Q30_PI;
                neg = 1'b1;
            end
            if (a > Q30_HALF_PI) begin
                a = (a > Q30_PI) ? 64'd0 : Q30_PI - a;
            end
            mag = (f_sine_q30(a) * FULL_SCALE + Q30_HALF) >> 30;
            if (mag > FULL_SCALE) begin
                mag = FULL_SCALE;
            end
            rom[k] = neg ? -SAMPLE_BITS'(mag) : SAMPLE_BITS'(mag);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = f_build();

    lso_pkg::t_stage_ctl           r_ctl;
    logic signed [SAMPLE_BITS-1:0] r_sine;
    logic signed [SAMPLE_BITS-1:0] r_mix;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_load) begin
            r_ctl <= i_ctl;
        end
    end

    // Registered table read
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sine <= SINE_ROM[i_addr];
            r_mix  <= i_mix;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_sine = r_sine;
    assign o_mix  = r_mix;

endmodule

// ===== rtl/core/lso_mix.sv =====
module lso_mix #(
    parameter int SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  lso_pkg::t_stage_ctl           i_ctl,
    input  logic [lso_pkg::AMP_W-1:0]     i_amplitude,
    input  logic signed [SAMPLE_BITS-1:0] i_sine,
    input  logic signed [SAMPLE_BITS-1:0] i_mix,
    output lso_pkg::t_stage_ctl           o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_mix_out,
    output logic                          o_saturated
);

    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = SAMPLE_BITS + lso_pkg::AMP_W + 2;
    localparam int SWEEP_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SWEEP_W + 1;

    localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0]  SUM_HI = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0]  SUM_LO = ~SUM_HI;

    lso_pkg::t_stage_ctl           r_ctl;
    logic signed [SAMPLE_BITS-1:0] r_mix_out;
    logic                          r_saturated;

    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      w_round;
    logic signed [SWEEP_W-1:0]     w_sweep;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [SAMPLE_BITS-1:0] n_mix_out;
    logic                          n_saturated;

    // Amplitude times sine, rounded, then saturating add; inactive words pass the mix input through
    always_comb begin
        w_prod  = PROD_W'($signed({1'b0, i_amplitude})) * PROD_W'(i_sine);
        w_round = w_prod + ROUND;
        w_sweep = w_round[PROD_W-1:FRAC_BITS];
        w_sum   = SUM_W'(w_sweep) + SUM_W'(i_mix);
        n_mix_out   = i_mix;
        n_saturated = 1'b0;
        if (i_ctl.active) begin
            if (w_sum > SUM_HI) begin
                n_mix_out   = SUM_HI[SAMPLE_BITS-1:0];
                n_saturated = 1'b1;
            end else if (w_sum < SUM_LO) begin
                n_mix_out   = SUM_LO[SAMPLE_BITS-1:0];
                n_saturated = 1'b1;
            end else begin
                n_mix_out   = w_sum[SAMPLE_BITS-1:0];
            end
        end
    end

    // Output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_load) begin
            r_ctl <= i_ctl;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mix_out   <= n_mix_out;
            r_saturated <= n_saturated;
        end
    end

    assign o_ctl       = r_ctl;
    assign o_mix_out   = r_mix_out;
    assign o_saturated = r_saturated;

endmodule

// ===== rtl/core/linear_sweep_oscillator_top.sv =====
// Channel   Handshake                 Word
// input     i_in_valid / o_in_ready   i_restart, i_mix_in
// output    o_out_valid / i_out_ready o_mix_out, o_active, o_saturated
// config    i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; a word passes
// through phase update, sine table read, then multiply and saturating add.
// Reset is synchronous: it empties the pipeline, clears phase, increment and
// sample index, and zeroes the configuration registers. An output stall holds
// each full stage with no empty stage after it; ready ripples back so the input
// keeps accepting while any stage has room. Table depth is a power of two.
module linear_sweep_oscillator_top #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_restart,
    input  logic signed [SAMPLE_BITS-1:0]       i_mix_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_mix_out,
    output logic                                o_active,
    output logic                                o_saturated,
    input  logic                                i_cfg_we,
    input  logic [lso_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lso_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH);

    lso_pkg::t_cfg                 w_cfg;
    lso_pkg::t_stage_ctl           w_s1_ctl;
    lso_pkg::t_stage_ctl           w_s2_ctl;
    lso_pkg::t_stage_ctl           w_s3_ctl;
    logic [ADDR_BITS-1:0]          w_s1_addr;
    logic signed [SAMPLE_BITS-1:0] w_s1_mix;
    logic signed [SAMPLE_BITS-1:0] w_s2_sine;
    logic signed [SAMPLE_BITS-1:0] w_s2_mix;
    logic                          w_load1;
    logic                          w_load2;
    logic                          w_load3;

    // A stage loads when it is empty or its word moves on
    assign w_load3 = !w_s3_ctl.valid || i_out_ready;
    assign w_load2 = !w_s2_ctl.valid || w_load3;
    assign w_load1 = !w_s1_ctl.valid || w_load2;

    lso_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lso_phase #(
        .PHASE_BITS  (PHASE_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_load     (w_load1),
        .i_restart  (i_restart),
        .i_mix_in   (i_mix_in),
        .i_cfg      (w_cfg),
        .o_ctl      (w_s1_ctl),
        .o_addr     (w_s1_addr),
        .o_mix      (w_s1_mix)
    );

    lso_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load2),
        .i_ctl   (w_s1_ctl),
        .i_addr  (w_s1_addr),
        .i_mix   (w_s1_mix),
        .o_ctl   (w_s2_ctl),
        .o_sine  (w_s2_sine),
        .o_mix   (w_s2_mix)
    );

    lso_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load3),
        .i_ctl       (w_s2_ctl),
        .i_amplitude (w_cfg.amplitude),
        .i_sine      (w_s2_sine),
        .i_mix       (w_s2_mix),
        .o_ctl       (w_s3_ctl),
        .o_mix_out   (o_mix_out),
        .o_saturated (o_saturated)
    );

    assign o_in_ready  = w_load1;
    assign o_out_valid = w_s3_ctl.valid;
    assign o_active    = w_s3_ctl.active;

endmodule

// ===== rtl/core/lso_checker.sv =====
`include "linear_sweep_oscillator_top_macros.svh"

module lso_checker #(
    parameter int SAMPLE_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_mix_out,
    input logic                          o_active,
    input logic                          o_saturated
);

    localparam logic signed [SAMPLE_BITS-1:0] MIX_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIX_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Output word holds while stalled
    `LSO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_mix_out), "output word changed while stalled")

    // Reset empties the output
    `LSO_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output valid after reset")

    // Empty output means no stage can block the input
    `LSO_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty output")

    // Pass-through words are never clipped
    `LSO_ASSERT_SAME(a_idle_no_clip, i_clk, i_rst_n, o_out_valid && !o_active, !o_saturated, "clip flagged outside sweep")

    // A clipped word sits on a rail
    `LSO_ASSERT_SAME(a_clip_rail, i_clk, i_rst_n, o_out_valid && o_saturated, (o_mix_out == MIX_MAX) || (o_mix_out == MIX_MIN), "clipped word off the rail")

endmodule

bind linear_sweep_oscillator_top lso_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lso_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_mix_out   (o_mix_out),
    .o_active    (o_active),
    .o_saturated (o_saturated)
);
